FILE: sv/hdp_pkg.sv
// Shared types, constants and character helpers for the hex dump record parser.
package hdp_pkg;

  localparam int CHAR_W      = 8;
  localparam int BLOCK_W     = 16;
  localparam int HALF_W      = 64;
  localparam int DATA_W      = 2 * HALF_W;
  localparam int COUNT_W     = 8;
  localparam int LIMIT_W     = 8;
  localparam int NIB_W       = 4;
  localparam int PREFIX_LEN  = 8;
  localparam int PREFIX_W    = $clog2(PREFIX_LEN);
  localparam int HEX_DIGITS  = DATA_W / NIB_W;
  localparam int HEXCNT_W    = $clog2(HEX_DIGITS);
  localparam int ACC_W       = BLOCK_W + 3;

  // APB side
  localparam int PDATA_W     = 32;
  localparam int PADDR_W     = 2;
  localparam logic [PADDR_W-1:0] ADDR_RECORD_LIMIT = 2'd0;
  localparam logic [LIMIT_W-1:0] RECORD_LIMIT_RESET = 8'd64;

  // Characters and numeric bounds
  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
  localparam logic [CHAR_W-1:0] CH_VT      = 8'd11;
  localparam logic [CHAR_W-1:0] CH_FF      = 8'd12;
  localparam logic [CHAR_W-1:0] CH_CR      = 8'd13;
  localparam logic [CHAR_W-1:0] CH_PLUS    = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;

  localparam logic [ACC_W-1:0]   MAG_SAT       = 19'd32768;
  localparam logic [BLOCK_W-1:0] MAG_SAT16     = 16'h8000;
  localparam logic [BLOCK_W-1:0] POS_MAX       = 16'h7FFF;
  localparam logic signed [BLOCK_W-1:0] TRAILER_BOUND = 16'sd128;
  localparam logic [1:0]         TRAILER_MASK  = 2'b11;

  localparam logic KIND_RECORD  = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef enum logic [2:0] {
    LP_PREFIX,
    LP_SP1,
    LP_TOKEN,
    LP_SP2,
    LP_HEX,
    LP_IGNORE
  } line_phase_t;

  typedef enum logic [1:0] {
    NP_WS,
    NP_DIG,
    NP_DONE
  } num_phase_t;

  typedef struct packed {
    logic                      kind;
    logic signed [BLOCK_W-1:0] block_number;
    logic [HALF_W-1:0]         data_high;
    logic [HALF_W-1:0]         data_low;
    logic [COUNT_W-1:0]        record_count;
    logic                      is_last;
  } hdp_result_t;

  // Expected character at each place of the line prefix "RFA dat "
  function automatic logic [CHAR_W-1:0] prefix_char(input logic [PREFIX_W-1:0] idx);
    logic [CHAR_W-1:0] c;
    unique case (idx)
      3'd0: c = 8'h52; // R
      3'd1: c = 8'h46; // F
      3'd2: c = 8'h41; // A
      3'd3: c = 8'h20;
      3'd4: c = 8'h64; // d
      3'd5: c = 8'h61; // a
      3'd6: c = 8'h74; // t
      3'd7: c = 8'h20;
      default: c = 8'h20;
    endcase
    return c;
  endfunction

  // {valid, nibble} for a hex character
  function automatic logic [NIB_W:0] hex_decode(input logic [CHAR_W-1:0] ch);
    logic [NIB_W:0] r;
    r = '0;
    if (ch >= CH_ZERO && ch <= CH_NINE) r = {1'b1, ch[NIB_W-1:0]};
    else if (ch >= 8'h61 && ch <= 8'h66) r = {1'b1, ch[NIB_W-1:0] + 4'd9};
    else if (ch >= 8'h41 && ch <= 8'h46) r = {1'b1, ch[NIB_W-1:0] + 4'd9};
    return r;
  endfunction

  function automatic logic is_white(input logic [CHAR_W-1:0] ch);
    return (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_VT) ||
           (ch == CH_FF) || (ch == CH_CR);
  endfunction

endpackage

FILE: sv/hdp_if.sv
// Stream interfaces: dump characters in, parsed records out.
interface hdp_char_if;
  import hdp_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              end_of_dump;

  modport source (output valid, output char_code, output end_of_dump, input ready);
  modport sink   (input valid, input char_code, input end_of_dump, output ready);
endinterface

interface hdp_rec_if;
  import hdp_pkg::*;
  logic                      valid;
  logic                      ready;
  logic                      kind;
  logic signed [BLOCK_W-1:0] block_number;
  logic [HALF_W-1:0]         data_high;
  logic [HALF_W-1:0]         data_low;
  logic [COUNT_W-1:0]        record_count;
  logic                      is_last;

  modport source (output valid, output kind, output block_number, output data_high,
                  output data_low, output record_count, output is_last, input ready);
  modport sink   (input valid, input kind, input block_number, input data_high,
                  input data_low, input record_count, input is_last, output ready);
endinterface

FILE: sv/hdp_parser.sv
// Line parser state: prefix match, block number, hex decode and record decision.
module hdp_parser (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        valid,
  input  logic                        step,
  input  logic [hdp_pkg::CHAR_W-1:0]  char_code,
  input  logic                        end_of_dump,
  input  logic [hdp_pkg::LIMIT_W-1:0] record_limit,
  output logic                        emit,
  output hdp_pkg::hdp_result_t        result
);
  import hdp_pkg::*;

  line_phase_t           phase, phase_next;
  logic [PREFIX_W-1:0]   prefix_pos, prefix_pos_next;
  logic [BLOCK_W-1:0]    num_value, num_value_next;
  logic                  num_neg, num_neg_next;
  num_phase_t            num_phase, num_phase_next;
  logic [HEXCNT_W-1:0]   hex_count, hex_count_next;
  logic [DATA_W-1:0]     data, data_next;
  logic [COUNT_W-1:0]    accepted, accepted_next;

  // number feed results for this character
  logic [BLOCK_W-1:0]    nf_value;
  logic                  nf_neg;
  num_phase_t            nf_phase;
  logic                  digit;
  logic [ACC_W-1:0]      acc;
  logic [BLOCK_W-1:0]    acc_sat;

  logic                  live;
  logic                  in_number;
  logic                  at_hex;
  logic [NIB_W:0]        hex_dec;
  logic [DATA_W-1:0]     shifted;
  logic                  last_digit;
  logic [BLOCK_W-1:0]    mag_clamped;
  logic signed [BLOCK_W-1:0] block;
  logic                  trailer;
  logic                  take;

  // decimal accumulate with saturation of the magnitude
  always_comb begin
    digit   = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
    acc     = ACC_W'({3'b000, num_value} * 19'd10) + ACC_W'(char_code[NIB_W-1:0]);
    acc_sat = (acc > MAG_SAT) ? MAG_SAT16 : acc[BLOCK_W-1:0];
  end

  // signed number parser, runs beside the token skipper
  always_comb begin
    nf_value = num_value;
    nf_neg   = num_neg;
    nf_phase = num_phase;
    unique case (num_phase)
      NP_WS: begin
        if (is_white(char_code)) begin
          nf_phase = NP_WS;
        end else if (char_code == CH_PLUS || char_code == CH_MINUS) begin
          nf_neg   = (char_code == CH_MINUS);
          nf_phase = NP_DIG;
        end else if (digit) begin
          nf_phase = NP_DIG;
          nf_value = acc_sat;
        end else begin
          nf_phase = NP_DONE;
        end
      end
      NP_DIG: begin
        if (digit) nf_value = acc_sat;
        else nf_phase = NP_DONE;
      end
      NP_DONE: nf_phase = NP_DONE;
      default: nf_phase = num_phase;
    endcase
  end

  // hex digit, block value and record decision
  always_comb begin
    live      = !end_of_dump && (char_code != CH_NEWLINE);
    in_number = live && (phase == LP_SP1 || phase == LP_TOKEN ||
                         phase == LP_SP2 || phase == LP_HEX);
    at_hex    = live && ((phase == LP_HEX) || (phase == LP_SP2 && char_code != CH_SPACE));
    hex_dec   = hex_decode(char_code);
    shifted   = {data[DATA_W-NIB_W-1:0], hex_dec[NIB_W-1:0]};
    last_digit = at_hex && hex_dec[NIB_W] && (hex_count == HEXCNT_W'(HEX_DIGITS - 1));
    mag_clamped = (nf_value > POS_MAX) ? POS_MAX : nf_value;
    block     = nf_neg ? $signed(BLOCK_W'(0) - nf_value) : $signed(mag_clamped);
    trailer   = (block < TRAILER_BOUND) && (block[1:0] == TRAILER_MASK);
    take      = last_digit && (block != '0) && !trailer && (accepted < record_limit);
  end

  // next state
  always_comb begin
    phase_next      = phase;
    prefix_pos_next = prefix_pos;
    num_value_next  = num_value;
    num_neg_next    = num_neg;
    num_phase_next  = num_phase;
    hex_count_next  = hex_count;
    data_next       = data;
    accepted_next   = accepted;
    if (end_of_dump) begin
      phase_next      = LP_PREFIX;
      prefix_pos_next = '0;
      num_value_next  = '0;
      num_neg_next    = 1'b0;
      num_phase_next  = NP_WS;
      hex_count_next  = '0;
      data_next       = '0;
      accepted_next   = '0;
    end else if (char_code == CH_NEWLINE) begin
      phase_next      = LP_PREFIX;
      prefix_pos_next = '0;
    end else begin
      if (in_number) begin
        num_value_next = nf_value;
        num_neg_next   = nf_neg;
        num_phase_next = nf_phase;
      end
      unique case (phase)
        LP_PREFIX: begin
          if (char_code == prefix_char(prefix_pos)) begin
            prefix_pos_next = prefix_pos + 1'b1;
            if (prefix_pos == PREFIX_W'(PREFIX_LEN - 1)) begin
              phase_next     = LP_SP1;
              num_value_next = '0;
              num_neg_next   = 1'b0;
              num_phase_next = NP_WS;
              hex_count_next = '0;
              data_next      = '0;
            end
          end else begin
            phase_next = LP_IGNORE;
          end
        end
        LP_SP1:   if (char_code != CH_SPACE) phase_next = LP_TOKEN;
        LP_TOKEN: if (char_code == CH_SPACE) phase_next = LP_SP2;
        LP_SP2, LP_HEX: begin
          if (at_hex) begin
            if (!hex_dec[NIB_W]) begin
              phase_next = LP_IGNORE;
            end else begin
              phase_next     = LP_HEX;
              data_next      = shifted;
              hex_count_next = hex_count + 1'b1;
              if (last_digit) phase_next = LP_IGNORE;
              if (take) accepted_next = accepted + 1'b1;
            end
          end
        end
        LP_IGNORE: phase_next = LP_IGNORE;
        default:   phase_next = LP_IGNORE;
      endcase
    end
  end

  // outputs
  always_comb begin
    emit = valid && (end_of_dump || take);
    if (end_of_dump) begin
      result.kind         = KIND_SUMMARY;
      result.block_number = '0;
      result.data_high    = '0;
      result.data_low     = '0;
      result.record_count = accepted;
      result.is_last      = 1'b1;
    end else begin
      result.kind         = KIND_RECORD;
      result.block_number = block;
      result.data_high    = shifted[DATA_W-1:HALF_W];
      result.data_low     = shifted[HALF_W-1:0];
      result.record_count = accepted + 1'b1;
      result.is_last      = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= LP_PREFIX;
      prefix_pos <= '0;
      num_value  <= '0;
      num_neg    <= 1'b0;
      num_phase  <= NP_WS;
      hex_count  <= '0;
      data       <= '0;
      accepted   <= '0;
    end else if (step) begin
      phase      <= phase_next;
      prefix_pos <= prefix_pos_next;
      num_value  <= num_value_next;
      num_neg    <= num_neg_next;
      num_phase  <= num_phase_next;
      hex_count  <= hex_count_next;
      data       <= data_next;
      accepted   <= accepted_next;
    end
  end

endmodule

FILE: sv/hex_dump_block_record_parser.sv
// Top level: input register, line parser, result register and APB register.
//
//  channel   dir  payload                                             handshake
//  char_in   in   char_code[7:0], end_of_dump                         valid/ready
//  rec_out   out  kind, block_number[15:0], data_high[63:0],
//                 data_low[63:0], record_count[7:0], is_last          valid/ready
//  apb       in   record_limit at address 0                           psel/penable
//
// One character per cycle unless a held result stalls it. Each character waits in
// the input register; as it advances, the parser updates its state and loads the
// result register in the same cycle, so a record is shown once its last hex digit advances.
// Reset (rst, synchronous) clears the parser and sets record_limit to 64.
// A held result stalls only characters that would produce another result.
module hex_dump_block_record_parser (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [hdp_pkg::PADDR_W-1:0] paddr,
  input  logic [hdp_pkg::PDATA_W-1:0] pwdata,
  output logic [hdp_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  hdp_char_if.sink                    char_in,
  hdp_rec_if.source                   rec_out
);
  import hdp_pkg::*;

  logic [LIMIT_W-1:0] record_limit;
  logic               s1_valid;
  logic [CHAR_W-1:0]  s1_char;
  logic               s1_eod;
  logic               emit;
  logic               advance;
  hdp_result_t        result;
  hdp_result_t        out_reg;
  logic               out_valid;

  // configuration register
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_RECORD_LIMIT) ? PDATA_W'(record_limit) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      record_limit <= RECORD_LIMIT_RESET;
    end else if (psel && penable && pwrite && pready && paddr == ADDR_RECORD_LIMIT) begin
      record_limit <= pwdata[LIMIT_W-1:0];
    end
  end

  // input register moves on unless its result finds the output occupied
  assign advance       = s1_valid && (!emit || !out_valid || rec_out.ready);
  assign char_in.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (char_in.ready) begin
      s1_valid <= char_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (char_in.ready && char_in.valid) begin
      s1_char <= char_in.char_code;
      s1_eod  <= char_in.end_of_dump;
    end
  end

  hdp_parser u_parser (
    .clk          (clk),
    .rst          (rst),
    .valid        (s1_valid),
    .step         (advance),
    .char_code    (s1_char),
    .end_of_dump  (s1_eod),
    .record_limit (record_limit),
    .emit         (emit),
    .result       (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && emit) begin
      out_valid <= 1'b1;
    end else if (rec_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) out_reg <= result;
  end

  assign rec_out.valid        = out_valid;
  assign rec_out.kind         = out_reg.kind;
  assign rec_out.block_number = out_reg.block_number;
  assign rec_out.data_high    = out_reg.data_high;
  assign rec_out.data_low     = out_reg.data_low;
  assign rec_out.record_count = out_reg.record_count;
  assign rec_out.is_last      = out_reg.is_last;

endmodule

FILE: sv/hdp_checker.sv
// Port-level checks for the hex dump record parser, bound to the top level.
module hdp_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [hdp_pkg::PADDR_W-1:0] paddr,
  input  logic [hdp_pkg::PDATA_W-1:0] prdata,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic                        out_kind,
  input  logic [hdp_pkg::BLOCK_W-1:0] out_block,
  input  logic [hdp_pkg::COUNT_W-1:0] out_count,
  input  logic                        out_last
);
  import hdp_pkg::*;

  // no result request right after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // a stalled result request stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_count) && $stable(out_kind))
    else $error("stalled result changed");

  // a data record carries a nonzero block and a nonzero count, never the last flag
  a_record_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind == KIND_RECORD |->
      out_block != '0 && out_count != '0 && !out_last)
    else $error("bad data record fields");

  // the limit register reads its reset value once reset ends
  a_limit_reset: assert property (@(posedge clk)
    $past(rst) && !rst && paddr == ADDR_RECORD_LIMIT |->
      prdata == PDATA_W'(RECORD_LIMIT_RESET))
    else $error("record limit reset value wrong");

endmodule

bind hex_dump_block_record_parser hdp_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .paddr     (paddr),
  .prdata    (prdata),
  .out_valid (rec_out.valid),
  .out_ready (rec_out.ready),
  .out_kind  (rec_out.kind),
  .out_block (rec_out.block_number),
  .out_count (rec_out.record_count),
  .out_last  (rec_out.is_last)
);
